/* sv/snow3g_keystream_generator_top_defines.svh */
// Assertion macros for the keystream generator.
`ifndef SNOW3G_KEYSTREAM_GENERATOR_TOP_DEFINES_SVH
`define SNOW3G_KEYSTREAM_GENERATOR_TOP_DEFINES_SVH

// Implication checked on every clock outside reset.
`define S3G_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked on every clock outside reset.
`define S3G_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/s3g_pkg.sv */
package s3g_pkg;

   localparam int unsigned WordWidth       = 32;
   localparam int unsigned LfsrDepth       = 16;
   localparam int unsigned CfgCount        = 8;
   localparam int unsigned CfgIndexWidth   = 3;
   localparam int unsigned CountWidth      = 7;
   localparam int unsigned InitRounds      = 32;
   localparam int unsigned MaxRequestWords = 64;

   localparam logic FUNC_INIT     = 1'b0;
   localparam logic FUNC_GENERATE = 1'b1;

   localparam logic [CfgIndexWidth-1:0] CFG_KEY_0 = 3'd0;
   localparam logic [CfgIndexWidth-1:0] CFG_KEY_1 = 3'd1;
   localparam logic [CfgIndexWidth-1:0] CFG_KEY_2 = 3'd2;
   localparam logic [CfgIndexWidth-1:0] CFG_KEY_3 = 3'd3;
   localparam logic [CfgIndexWidth-1:0] CFG_IV_0  = 3'd4;
   localparam logic [CfgIndexWidth-1:0] CFG_IV_1  = 3'd5;
   localparam logic [CfgIndexWidth-1:0] CFG_IV_2  = 3'd6;
   localparam logic [CfgIndexWidth-1:0] CFG_IV_3  = 3'd7;

   typedef logic [WordWidth-1:0] word_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;   // load LFSR/FSM from key and IV
      logic step;   // clock LFSR and FSM once
      logic mix;    // feed FSM output into LFSR feedback
   } dp_cmd_type;

   localparam logic [7:0] SR_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] SQ_BOX [256] = '{
    8'h25,8'h24,8'h73,8'h67,8'hd7,8'hae,8'h5c,8'h30,8'ha4,8'hee,8'h6e,8'hcb,8'h7d,8'hb5,8'h82,8'hdb,
    8'he4,8'h8e,8'h48,8'h49,8'h4f,8'h5d,8'h6a,8'h78,8'h70,8'h88,8'he8,8'h5f,8'h5e,8'h84,8'h65,8'he2,
    8'hd8,8'he9,8'hcc,8'hed,8'h40,8'h2f,8'h11,8'h28,8'h57,8'hd2,8'hac,8'he3,8'h4a,8'h15,8'h1b,8'hb9,
    8'hb2,8'h80,8'h85,8'ha6,8'h2e,8'h02,8'h47,8'h29,8'h07,8'h4b,8'h0e,8'hc1,8'h51,8'haa,8'h89,8'hd4,
    8'hca,8'h01,8'h46,8'hb3,8'hef,8'hdd,8'h44,8'h7b,8'hc2,8'h7f,8'hbe,8'hc3,8'h9f,8'h20,8'h4c,8'h64,
    8'h83,8'ha2,8'h68,8'h42,8'h13,8'hb4,8'h41,8'hcd,8'hba,8'hc6,8'hbb,8'h6d,8'h4d,8'h71,8'h21,8'hf4,
    8'h8d,8'hb0,8'he5,8'h93,8'hfe,8'h8f,8'he6,8'hcf,8'h43,8'h45,8'h31,8'h22,8'h37,8'h36,8'h96,8'hfa,
    8'hbc,8'h0f,8'h08,8'h52,8'h1d,8'h55,8'h1a,8'hc5,8'h4e,8'h23,8'h69,8'h7a,8'h92,8'hff,8'h5b,8'h5a,
    8'heb,8'h9a,8'h1c,8'ha9,8'hd1,8'h7e,8'h0d,8'hfc,8'h50,8'h8a,8'hb6,8'h62,8'hf5,8'h0a,8'hf8,8'hdc,
    8'h03,8'h3c,8'h0c,8'h39,8'hf1,8'hb8,8'hf3,8'h3d,8'hf2,8'hd5,8'h97,8'h66,8'h81,8'h32,8'ha0,8'h00,
    8'h06,8'hce,8'hf6,8'hea,8'hb7,8'h17,8'hf7,8'h8c,8'h79,8'hd6,8'ha7,8'hbf,8'h8b,8'h3f,8'h1f,8'h53,
    8'h63,8'h75,8'h35,8'h2c,8'h60,8'hfd,8'h27,8'hd3,8'h94,8'ha5,8'h7c,8'ha1,8'h05,8'h58,8'h2d,8'hbd,
    8'hd9,8'hc7,8'haf,8'h6b,8'h54,8'h0b,8'he0,8'h38,8'h04,8'hc8,8'h9d,8'he7,8'h14,8'hb1,8'h87,8'h9c,
    8'hdf,8'h6f,8'hf9,8'hda,8'h2a,8'hc4,8'h59,8'h16,8'h74,8'h91,8'hab,8'h26,8'h61,8'h76,8'h34,8'h2b,
    8'had,8'h99,8'hfb,8'h72,8'hec,8'h33,8'h12,8'hde,8'h98,8'h3b,8'hc0,8'h9b,8'h3e,8'h18,8'h10,8'h3a,
    8'h56,8'he1,8'h77,8'hc9,8'h1e,8'h9e,8'h95,8'ha3,8'h90,8'h19,8'ha8,8'h6c,8'h09,8'hd0,8'hf0,8'h86};

   function automatic logic [7:0] times_x(input logic [7:0] v, input logic [7:0] poly);
      times_x = {v[6:0], 1'b0} ^ (v[7] ? poly : 8'h00);
   endfunction

   // v * x^n; the constant n makes the loop a fixed linear map after synthesis.
   function automatic logic [7:0] times_x_pow(input logic [7:0] v, input int unsigned n);
      logic [7:0] r;
      r = v;
      for (int unsigned i = 0; i < n; i++) r = times_x(r, 8'ha9);
      return r;
   endfunction

   function automatic word_type alpha_mul(input logic [7:0] c);
      return {times_x_pow(c, 23), times_x_pow(c, 245), times_x_pow(c, 48),
              times_x_pow(c, 239)};
   endfunction

   function automatic word_type alpha_div(input logic [7:0] c);
      return {times_x_pow(c, 16), times_x_pow(c, 39), times_x_pow(c, 6),
              times_x_pow(c, 64)};
   endfunction

   function automatic word_type mix_col(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c, input logic [7:0] d,
                                        input logic [7:0] poly);
      logic [7:0] a2, b2, c2, d2;
      a2 = times_x(a, poly);
      b2 = times_x(b, poly);
      c2 = times_x(c, poly);
      d2 = times_x(d, poly);
      return {a2 ^ b ^ c ^ d2 ^ d, a2 ^ a ^ b2 ^ c ^ d,
              a ^ b2 ^ b ^ c2 ^ d, a ^ b ^ c2 ^ c ^ d2};
   endfunction

endpackage

/* sv/snow3g_keystream_generator_top.sv */
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  func, word_count
// rsp_      out        rsp_valid/rsp_ready  keystream_word, last_word
// csr_      in         csr_write_enable     csr_index, csr_write_data
//
// Init takes a load step plus 32 rounds, one LFSR/FSM clock per cycle.
// Generate takes the accept, a discard step, one word per cycle while the output register
// can take it, and a hold state for the last word to leave; at zero words it ends after the discard.
// The single output register sets the pace under rsp stalls.
// Requests are taken only when the sequencer is idle and the last word is gone.
// Reset (synchronous) clears LFSR, FSM, key and IV registers.
module snow3g_keystream_generator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [s3g_pkg::CountWidth-1:0]      req_word_count,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [s3g_pkg::WordWidth-1:0]       rsp_keystream_word,
   output logic                                rsp_last_word,
   input  logic                                csr_write_enable,
   input  logic [s3g_pkg::CfgIndexWidth-1:0]   csr_index,
   input  logic [s3g_pkg::WordWidth-1:0]       csr_write_data
);
   import s3g_pkg::*;
`include "snow3g_keystream_generator_top_defines.svh"

   // key and IV registers, latched into the LFSR on an init request
   word_type   key_ff [4];
   word_type   iv_ff [4];
   dp_cmd_type cmd;
   word_type   keystream;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            key_ff[i] <= '0;
            iv_ff[i]  <= '0;
         end
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CFG_KEY_0: key_ff[0] <= csr_write_data;
            CFG_KEY_1: key_ff[1] <= csr_write_data;
            CFG_KEY_2: key_ff[2] <= csr_write_data;
            CFG_KEY_3: key_ff[3] <= csr_write_data;
            CFG_IV_0:  iv_ff[0]  <= csr_write_data;
            CFG_IV_1:  iv_ff[1]  <= csr_write_data;
            CFG_IV_2:  iv_ff[2]  <= csr_write_data;
            CFG_IV_3:  iv_ff[3]  <= csr_write_data;
            default: ;
         endcase
      end
   end

   s3g_control u_control (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_word_count     (req_word_count),
      .keystream          (keystream),
      .cmd                (cmd),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_keystream_word (rsp_keystream_word),
      .rsp_last_word      (rsp_last_word)
   );

   s3g_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .key       (key_ff),
      .iv        (iv_ff),
      .keystream (keystream)
   );

   // loading and stepping never coincide
   `S3G_ASSERT_IMPL(a_load_excl, clock, reset, cmd.load, !cmd.step, "load with step")
   // feedback mixing only during init rounds, never alongside a word
   `S3G_ASSERT_IMPL(a_mix_no_rsp, clock, reset, cmd.mix, !rsp_valid, "mix during output")
   // a load is followed by a stepping round
   `S3G_ASSERT_NEXT(a_load_step, clock, reset, cmd.load, cmd.step && cmd.mix, "no init round")
endmodule

/* sv/s3g_datapath.sv */
module s3g_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  s3g_pkg::dp_cmd_type     cmd,
   input  s3g_pkg::word_type       key [4],
   input  s3g_pkg::word_type       iv [4],
   output s3g_pkg::word_type       keystream
);
   import s3g_pkg::*;

   word_type lfsr_ff [LfsrDepth];
   word_type lfsr_in [LfsrDepth];
   word_type r1_ff, r2_ff, r3_ff;
   word_type r1_in, r2_in, r3_in;
   word_type fsm_out, feedback;

   assign fsm_out   = (lfsr_ff[15] + r1_ff) ^ r2_ff;
   assign keystream = fsm_out ^ lfsr_ff[0];
   assign feedback  = {lfsr_ff[0][23:0], 8'h00} ^ alpha_mul(lfsr_ff[0][31:24])
                    ^ lfsr_ff[2] ^ {8'h00, lfsr_ff[11][31:8]}
                    ^ alpha_div(lfsr_ff[11][7:0]) ^ (cmd.mix ? fsm_out : '0);

   always_comb begin
      lfsr_in = lfsr_ff;
      r1_in   = r1_ff;
      r2_in   = r2_ff;
      r3_in   = r3_ff;
      if (cmd.load) begin
         lfsr_in[15] = key[3] ^ iv[0];
         lfsr_in[14] = key[2];
         lfsr_in[13] = key[1];
         lfsr_in[12] = key[0] ^ iv[1];
         lfsr_in[11] = ~key[3];
         lfsr_in[10] = ~key[2] ^ iv[2];
         lfsr_in[9]  = ~key[1] ^ iv[3];
         lfsr_in[8]  = ~key[0];
         lfsr_in[7]  = key[3];
         lfsr_in[6]  = key[2];
         lfsr_in[5]  = key[1];
         lfsr_in[4]  = key[0];
         lfsr_in[3]  = ~key[3];
         lfsr_in[2]  = ~key[2];
         lfsr_in[1]  = ~key[1];
         lfsr_in[0]  = ~key[0];
         r1_in = '0;
         r2_in = '0;
         r3_in = '0;
      end else if (cmd.step) begin
         for (int i = 0; i < LfsrDepth - 1; i++) lfsr_in[i] = lfsr_ff[i+1];
         lfsr_in[LfsrDepth-1] = feedback;
         r1_in = r2_ff + (r3_ff ^ lfsr_ff[5]);
         r2_in = mix_col(SR_BOX[r1_ff[31:24]], SR_BOX[r1_ff[23:16]],
                         SR_BOX[r1_ff[15:8]], SR_BOX[r1_ff[7:0]], 8'h1b);
         r3_in = mix_col(SQ_BOX[r2_ff[31:24]], SQ_BOX[r2_ff[23:16]],
                         SQ_BOX[r2_ff[15:8]], SQ_BOX[r2_ff[7:0]], 8'h69);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LfsrDepth; i++) lfsr_ff[i] <= '0;
         r1_ff <= '0;
         r2_ff <= '0;
         r3_ff <= '0;
      end else begin
         lfsr_ff <= lfsr_in;
         r1_ff   <= r1_in;
         r2_ff   <= r2_in;
         r3_ff   <= r3_in;
      end
   end
endmodule

/* sv/s3g_control.sv */
module s3g_control (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [s3g_pkg::CountWidth-1:0] req_word_count,
   input  s3g_pkg::word_type             keystream,
   output s3g_pkg::dp_cmd_type           cmd,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output s3g_pkg::word_type             rsp_keystream_word,
   output logic                          rsp_last_word
);
   import s3g_pkg::*;

   typedef enum logic [2:0] {ST_IDLE, ST_INIT, ST_DISCARD, ST_GEN, ST_HOLD} state_type;

   state_type               state_ff, state_in;
   logic [CountWidth-1:0]   cnt_ff, cnt_in;
   logic                    valid_ff, valid_in;
   word_type                word_ff, word_in;
   logic                    last_ff, last_in;
   logic [CountWidth-1:0]   sat_count;

   assign sat_count = (req_word_count > CountWidth'(MaxRequestWords))
                      ? CountWidth'(MaxRequestWords) : req_word_count;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_keystream_word = word_ff;
   assign rsp_last_word = last_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff && !rsp_ready;
      word_in  = word_ff;
      last_in  = last_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_INIT) begin
                  cmd.load = 1'b1;
                  cnt_in   = CountWidth'(InitRounds);
                  state_in = ST_INIT;
               end else begin
                  cnt_in   = sat_count;
                  state_in = ST_DISCARD;
               end
            end
         end
         ST_INIT: begin
            cmd.step = 1'b1;
            cmd.mix  = 1'b1;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == CountWidth'(1)) state_in = ST_IDLE;
         end
         ST_DISCARD: begin
            cmd.step = 1'b1;
            state_in = (cnt_ff == '0) ? ST_IDLE : ST_GEN;
         end
         ST_GEN: begin
            // one word per step; stall while the output register is full
            if (!valid_ff || rsp_ready) begin
               cmd.step = 1'b1;
               valid_in = 1'b1;
               word_in  = keystream;
               last_in  = (cnt_ff == CountWidth'(1));
               cnt_in   = cnt_ff - 1'b1;
               state_in = (cnt_ff == CountWidth'(1)) ? ST_HOLD : ST_GEN;
            end
         end
         ST_HOLD: begin
            if (!valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
      last_ff <= last_in;
   end
endmodule

/* tb/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import s3g_pkg::*;

   // Run limit: covers the worst case per request, including a receiver stall
   // on each of 64 words, several times over for every item.
   localparam int unsigned CycleLimit  = 2000000;
   // Init gives no word back, so settle well past the init rounds.
   localparam int unsigned SettleCycles = 80;

   typedef struct {
      word_type keystream_word;
      logic     last_word;
   } keystream_entry_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_func = FUNC_INIT;
   logic [CountWidth-1:0]    req_word_count = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   word_type                 rsp_keystream_word;
   logic                     rsp_last_word;
   logic                     csr_write_enable = 1'b0;
   logic [CfgIndexWidth-1:0] csr_index = CFG_KEY_0;
   word_type                 csr_write_data = '0;

   snow3g_keystream_generator_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_word_count     (req_word_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_keystream_word (rsp_keystream_word),
      .rsp_last_word      (rsp_last_word),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #4 clock = ~clock;

   // Cycle counter doubles as the watchdog.
   int unsigned cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Shadow of the cipher: key/IV registers, LFSR s0..s15, FSM R1..R3.
   word_type key_iv_shadow [CfgCount];
   word_type lfsr_shadow [LfsrDepth];
   word_type fsm_r1, fsm_r2, fsm_r3;

   keystream_entry_type keystream_expected [$];
   int unsigned mismatch_count = 0;

   // Knobs for the sender and the receiver.
   bit          idling_on = 1'b1;
   int unsigned rsp_hold_cycles = 0;
   bit          req_valid_up = 1'b0;

   // ---------------- cipher predictor ----------------
   function automatic logic [7:0] gf_double(input logic [7:0] v, input logic [7:0] poly);
      return {v[6:0], 1'b0} ^ (v[7] ? poly : 8'h00);
   endfunction

   function automatic logic [7:0] gf_power(input logic [7:0] v, input int n);
      for (int i = 0; i < n; i++) v = gf_double(v, 8'ha9);
      return v;
   endfunction

   function automatic word_type lfsr_alpha_mul(input logic [7:0] c);
      return {gf_power(c, 23), gf_power(c, 245), gf_power(c, 48), gf_power(c, 239)};
   endfunction

   function automatic word_type lfsr_alpha_div(input logic [7:0] c);
      return {gf_power(c, 16), gf_power(c, 39), gf_power(c, 6), gf_power(c, 64)};
   endfunction

   // S-box substitution followed by the column mix; use_sq picks S2.
   function automatic word_type sbox_mix(input bit use_sq, input word_type w,
                                         input logic [7:0] poly);
      logic [7:0] a, b, c, d, a2, b2, c2, d2;
      a = use_sq ? SQ_BOX[w[31:24]] : SR_BOX[w[31:24]];
      b = use_sq ? SQ_BOX[w[23:16]] : SR_BOX[w[23:16]];
      c = use_sq ? SQ_BOX[w[15:8]]  : SR_BOX[w[15:8]];
      d = use_sq ? SQ_BOX[w[7:0]]   : SR_BOX[w[7:0]];
      a2 = gf_double(a, poly);
      b2 = gf_double(b, poly);
      c2 = gf_double(c, poly);
      d2 = gf_double(d, poly);
      return {a2 ^ b ^ c ^ d2 ^ d, a2 ^ a ^ b2 ^ c ^ d,
              a ^ b2 ^ b ^ c2 ^ d, a ^ b ^ c2 ^ c ^ d2};
   endfunction

   function automatic word_type fsm_advance();
      word_type f, r;
      f = (lfsr_shadow[15] + fsm_r1) ^ fsm_r2;
      r = fsm_r2 + (fsm_r3 ^ lfsr_shadow[5]);
      fsm_r3 = sbox_mix(1'b1, fsm_r2, 8'h69);
      fsm_r2 = sbox_mix(1'b0, fsm_r1, 8'h1b);
      fsm_r1 = r;
      return f;
   endfunction

   function automatic void lfsr_advance(input word_type extra);
      word_type s0, s11, fb;
      s0  = lfsr_shadow[0];
      s11 = lfsr_shadow[11];
      fb = {s0[23:0], 8'h00} ^ lfsr_alpha_mul(s0[31:24]) ^ lfsr_shadow[2]
         ^ {8'h00, s11[31:8]} ^ lfsr_alpha_div(s11[7:0]) ^ extra;
      for (int i = 0; i < LfsrDepth - 1; i++) lfsr_shadow[i] = lfsr_shadow[i+1];
      lfsr_shadow[15] = fb;
   endfunction

   function automatic void predict_keystream(input logic func,
                                             input logic [CountWidth-1:0] count);
      word_type k0, k1, k2, k3, f;
      int n;
      keystream_entry_type e;
      k0 = key_iv_shadow[CFG_KEY_0];
      k1 = key_iv_shadow[CFG_KEY_1];
      k2 = key_iv_shadow[CFG_KEY_2];
      k3 = key_iv_shadow[CFG_KEY_3];
      if (func == FUNC_INIT) begin
         lfsr_shadow[15] = k3 ^ key_iv_shadow[CFG_IV_0];
         lfsr_shadow[14] = k2;
         lfsr_shadow[13] = k1;
         lfsr_shadow[12] = k0 ^ key_iv_shadow[CFG_IV_1];
         lfsr_shadow[11] = ~k3;
         lfsr_shadow[10] = ~k2 ^ key_iv_shadow[CFG_IV_2];
         lfsr_shadow[9]  = ~k1 ^ key_iv_shadow[CFG_IV_3];
         lfsr_shadow[8]  = ~k0;
         lfsr_shadow[7]  = k3;
         lfsr_shadow[6]  = k2;
         lfsr_shadow[5]  = k1;
         lfsr_shadow[4]  = k0;
         lfsr_shadow[3]  = ~k3;
         lfsr_shadow[2]  = ~k2;
         lfsr_shadow[1]  = ~k1;
         lfsr_shadow[0]  = ~k0;
         fsm_r1 = '0;
         fsm_r2 = '0;
         fsm_r3 = '0;
         for (int i = 0; i < InitRounds; i++) lfsr_advance(fsm_advance());
      end else begin
         n = (count > MaxRequestWords) ? MaxRequestWords : count;
         // discard clock
         f = fsm_advance();
         lfsr_advance('0);
         for (int i = 0; i < n; i++) begin
            f = fsm_advance();
            e.keystream_word = f ^ lfsr_shadow[0];
            e.last_word      = (i + 1 == n);
            keystream_expected.push_back(e);
            lfsr_advance('0);
         end
      end
   endfunction

   // ---------------- request side ----------------
   task automatic send_request(input logic func, input logic [CountWidth-1:0] count);
      int unsigned gap;
      gap = idling_on ? $urandom_range(0, 12) : 0;
      // valid stays up between back-to-back requests; only drop it for a gap
      if (gap > 0 && req_valid_up) begin
         req_valid    <= 1'b0;
         req_valid_up = 1'b0;
      end
      repeat (gap) @(posedge clock);
      if (gap == 0) @(posedge clock);
      req_valid      <= 1'b1;
      req_func       <= func;
      req_word_count <= count;
      req_valid_up   = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_keystream(func, count);
   endtask

   task automatic drop_request();
      @(posedge clock);
      req_valid    <= 1'b0;
      req_valid_up = 1'b0;
   endtask

   // Block is idle once every word is out and an init has had time to finish.
   task automatic wait_idle();
      if (req_valid_up) drop_request();
      while (keystream_expected.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic load_key_iv(input word_type vals [CfgCount]);
      wait_idle();
      for (int i = 0; i < CfgCount; i++) begin
         @(posedge clock);
         csr_write_enable <= 1'b1;
         csr_index        <= i[CfgIndexWidth-1:0];
         csr_write_data   <= vals[i];
         key_iv_shadow[i] = vals[i];
      end
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // ---------------- result side ----------------
   initial begin : receiver
      int unsigned stall;
      keystream_entry_type e;
      @(negedge reset);
      forever begin
         if (rsp_hold_cycles > 0) stall = rsp_hold_cycles;
         else stall = idling_on ? $urandom_range(0, 12) : 0;
         rsp_hold_cycles = 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (keystream_expected.size() == 0) begin
            $error("keystream_word: unexpected word %h", rsp_keystream_word);
            mismatch_count++;
         end else begin
            e = keystream_expected.pop_front();
            if (rsp_keystream_word !== e.keystream_word) begin
               $error("keystream_word: expected %h actual %h",
                      e.keystream_word, rsp_keystream_word);
               mismatch_count++;
            end
            if (rsp_last_word !== e.last_word) begin
               $error("last_word: expected %b actual %b", e.last_word, rsp_last_word);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------- tests ----------------
   // Generate straight out of reset runs on the all-zero state.
   task automatic test_generate_from_reset();
      send_request(FUNC_GENERATE, 7'd5);
      send_request(FUNC_GENERATE, 7'd0);
      send_request(FUNC_GENERATE, 7'd1);
   endtask

   // Key/IV extremes, full and oversized counts, zero count, ignored count on init.
   task automatic test_directed();
      word_type vals [CfgCount];
      foreach (vals[i]) vals[i] = '0;
      load_key_iv(vals);
      send_request(FUNC_INIT, 7'd127);
      send_request(FUNC_GENERATE, 7'd64);
      send_request(FUNC_GENERATE, 7'd127);
      foreach (vals[i]) vals[i] = '1;
      load_key_iv(vals);
      send_request(FUNC_GENERATE, 7'd2);   // new key not live until init
      send_request(FUNC_INIT, 7'd0);
      send_request(FUNC_GENERATE, 7'd65);
      send_request(FUNC_GENERATE, 7'd0);
      send_request(FUNC_GENERATE, 7'd1);
      foreach (vals[i]) vals[i] = (i % 2) ? 32'haaaa_5555 : 32'h5555_aaaa;
      load_key_iv(vals);
      send_request(FUNC_INIT, 7'd64);
      send_request(FUNC_INIT, 7'd3);        // init right after init
      send_request(FUNC_GENERATE, 7'd63);
   endtask

   // Long receiver hold-off while requests keep coming.
   task automatic test_backpressure();
      rsp_hold_cycles = 400;
      for (int i = 0; i < 12; i++)
         send_request(FUNC_GENERATE, CountWidth'($urandom_range(1, 16)));
   endtask

   task automatic test_random(input int unsigned phases, input int unsigned per_phase);
      word_type vals [CfgCount];
      int unsigned pick;
      logic [CountWidth-1:0] count;
      for (int p = 0; p < phases; p++) begin
         foreach (vals[i]) vals[i] = $urandom();
         if (p == 1) vals[CFG_KEY_0] = '1;
         if (p == 2) vals[CFG_IV_3]  = '0;
         load_key_iv(vals);
         idling_on = (p != 2);      // one phase with no idling at all
         send_request(FUNC_INIT, CountWidth'($urandom()));
         for (int i = 0; i < per_phase; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) count = CountWidth'($urandom_range(0, 6));
            else if (pick < 85) count = CountWidth'($urandom_range(7, 40));
            else count = CountWidth'($urandom_range(41, 127));
            send_request((pick % 11 == 0) ? FUNC_INIT : FUNC_GENERATE, count);
         end
      end
      idling_on = 1'b1;
   endtask

   initial begin
      foreach (key_iv_shadow[i]) key_iv_shadow[i] = '0;
      foreach (lfsr_shadow[i]) lfsr_shadow[i] = '0;
      fsm_r1 = '0;
      fsm_r2 = '0;
      fsm_r3 = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_generate_from_reset();
      test_directed();
      test_backpressure();
      test_random(5, 65);

      wait_idle();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
